// ----- rtl/rk4_pkg.sv -----
// Shared constants, register indexes and the saturation helper of the RK4 stepper.
package rk4_pkg;

  localparam int WORD_W    = 32;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] WORD_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN64 = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_START_X   = 2'd1,
    REG_START_Y   = 2'd2
  } cfg_reg_t;

  // clamp a wide signed value into the 32-bit signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX64) begin
      r = WORD_W'(WORD_MAX64);
    end else if (v < WORD_MIN64) begin
      r = WORD_W'(WORD_MIN64);
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/rk4_if.sv -----
// Valid/ready channel interfaces for step requests and step results.
interface rk4_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rk4_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rk4_pkg::WORD_W-1:0]  slope_one;
  logic signed [rk4_pkg::WORD_W-1:0]  slope_two;
  logic signed [rk4_pkg::WORD_W-1:0]  slope_three;
  logic signed [rk4_pkg::WORD_W-1:0]  slope_four;
  logic signed [rk4_pkg::WORD_W-1:0]  increment;
  logic signed [rk4_pkg::WORD_W-1:0]  x_after;
  logic signed [rk4_pkg::WORD_W-1:0]  y_after;

  modport source (output valid, output slope_one, output slope_two, output slope_three,
                  output slope_four, output increment, output x_after, output y_after,
                  input ready);
  modport sink   (input valid, input slope_one, input slope_two, input slope_three,
                  input slope_four, input increment, input x_after, input y_after,
                  output ready);
endinterface

// ----- rtl/rk4_mul_unit.sv -----
// Shared two-stage fixed-point multiplier: product register, then round, shift, saturate.
module rk4_mul_unit #(
  parameter int FRAC_BITS = rk4_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic signed [rk4_pkg::WORD_W-1:0] op_a,
  input  logic signed [rk4_pkg::WORD_W-1:0] op_b,
  output logic signed [rk4_pkg::WORD_W-1:0] res
);

  localparam logic signed [63:0] ROUND_ADD = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0]                 prod_r;
  logic signed [63:0]                 rounded;
  logic signed [63:0]                 shifted;
  logic signed [rk4_pkg::WORD_W-1:0]  res_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
    res_r  <= rk4_pkg::sat_word(shifted);
  end

  // arithmetic shift gives floor rounding after the half-LSB add
  assign rounded = prod_r + ROUND_ADD;
  assign shifted = rounded >>> FRAC_BITS;
  assign res     = res_r;

endmodule

// ----- rtl/rk4_ode_stepper_core.sv -----
// RK4 stepper for dy/dx = 0.1x^2 + 0.1y^2: sequencer around one shared multiplier.
// Each step computes the four slopes in turn on the two-stage multiplier, then runs a
// radix-16 divide by 6; the result beat waits in S_UPD while the previous result is
// still unread. A new step request is taken only in S_IDLE, after the last step ends.
// Reset (rst_n, synchronous): x = y = 0, h = 6554, start values 0, no result pending.
module rk4_ode_stepper_core #(
  parameter int FRAC_BITS = rk4_pkg::FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rk4_pkg::WORD_W-1:0]           cfg_wdata,
  rk4_in_if.sink                               in_chan,
  rk4_out_if.source                            out_chan
);

  localparam int W         = rk4_pkg::WORD_W;
  localparam int SUM_W     = W + 3;
  localparam int NUM_W     = 36;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = NUM_W / DIGIT_W;
  localparam int REM_W     = 3;
  localparam int V_W       = REM_W + DIGIT_W;
  localparam logic signed [W-1:0] TENTH =
    W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_LOAD = 16'b0000_0000_0000_0010,
    S_SQX  = 16'b0000_0000_0000_0100,
    S_SQY  = 16'b0000_0000_0000_1000,
    S_CAPX = 16'b0000_0000_0001_0000,
    S_SUMS = 16'b0000_0000_0010_0000,
    S_FSC  = 16'b0000_0000_0100_0000,
    S_W1   = 16'b0000_0000_1000_0000,
    S_HM   = 16'b0000_0001_0000_0000,
    S_W2   = 16'b0000_0010_0000_0000,
    S_KCAP = 16'b0000_0100_0000_0000,
    S_SUM6 = 16'b0000_1000_0000_0000,
    S_DIVI = 16'b0001_0000_0000_0000,
    S_DIV  = 16'b0010_0000_0000_0000,
    S_FIN  = 16'b0100_0000_0000_0000,
    S_UPD  = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [rk4_pkg::STEP_W-1:0] step_size_r;
  logic signed [W-1:0]        start_x_r, start_y_r;
  logic signed [W-1:0]        x_r, y_r;
  logic signed [W-1:0]        ex_r, ey_r, xm_r, xh_r, sqx_r, s_r, inc_r;
  logic signed [W-1:0]        k_r [4];
  logic [1:0]                 kidx_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [NUM_W-1:0]           num_r;
  logic [REM_W-1:0]           rem_r;
  logic                       neg_r;
  logic [3:0]                 dcnt_r;
  logic                       out_valid_r;

  logic signed [W-1:0]        h_s;
  logic signed [W-1:0]        mul_a, mul_b, mul_res, k_half;
  logic [NUM_W-1:0]           mag;
  logic [V_W-1:0]             dv;
  logic [DIGIT_W-1:0]         qd;
  logic [V_W-1:0]             drem;
  logic                       in_beat, out_free;

  assign h_s      = $signed({1'b0, step_size_r});
  assign in_beat  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign k_half   = mul_res >>> 1;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;

  rk4_mul_unit #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = ex_r; mul_b = ex_r;    end
      S_SQY:   begin mul_a = ey_r; mul_b = ey_r;    end
      S_HM:    begin mul_a = h_s;  mul_b = mul_res; end
      default: begin mul_a = s_r;  mul_b = TENTH;   end
    endcase
  end

  // magnitude of the weighted sum; half the divisor is added in S_DIVI for round-half-away
  assign mag = sum_r[SUM_W-1] ? NUM_W'(-NUM_W'(sum_r)) : NUM_W'(sum_r);

  // one radix-16 quotient digit; remainder stays below 6
  always_comb begin
    dv = {rem_r, num_r[NUM_W-1 -: DIGIT_W]};
    qd = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (dv >= V_W'(6 * k)) qd = DIGIT_W'(k);
    end
    drem = dv - ({{(V_W-DIGIT_W){1'b0}}, qd} * V_W'(6));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_beat) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_CAPX;
      S_CAPX: state_nxt = S_SUMS;
      S_SUMS: state_nxt = S_FSC;
      S_FSC:  state_nxt = S_W1;
      S_W1:   state_nxt = S_HM;
      S_HM:   state_nxt = S_W2;
      S_W2:   state_nxt = S_KCAP;
      S_KCAP: state_nxt = (kidx_r == 2'd3) ? S_SUM6 : S_SQX;
      S_SUM6: state_nxt = S_DIVI;
      S_DIVI: state_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 4'(DIV_STEPS - 1)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_UPD;
      S_UPD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_size_r <= rk4_pkg::STEP_W'(6554);
      start_x_r   <= '0;
      start_y_r   <= '0;
      x_r         <= '0;
      y_r         <= '0;
      kidx_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rk4_pkg::REG_STEP_SIZE: step_size_r <= cfg_wdata[rk4_pkg::STEP_W-1:0];
          rk4_pkg::REG_START_X:   start_x_r   <= $signed(cfg_wdata);
          rk4_pkg::REG_START_Y:   start_y_r   <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_beat && in_chan.restart) begin
        x_r <= start_x_r;
        y_r <= start_y_r;
      end
      if (state_r == S_LOAD) kidx_r <= '0;
      if (state_r == S_KCAP) kidx_r <= kidx_r + 2'd1;
      if (state_r == S_DIVI) dcnt_r <= '0;
      if (state_r == S_DIV)  dcnt_r <= dcnt_r + 4'd1;
      if (state_r == S_UPD && out_free) begin
        out_valid_r <= 1'b1;
        x_r         <= xh_r;
        y_r         <= rk4_pkg::sat_word(64'(y_r) + 64'(inc_r));
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        ex_r <= x_r;
        ey_r <= y_r;
        xm_r <= rk4_pkg::sat_word(64'(x_r) + 64'(h_s >>> 1));
        xh_r <= rk4_pkg::sat_word(64'(x_r) + 64'(h_s));
      end
      S_CAPX: sqx_r <= mul_res;
      S_SUMS: s_r   <= rk4_pkg::sat_word(64'(sqx_r) + 64'(mul_res));
      S_KCAP: begin
        k_r[kidx_r] <= mul_res;
        if (kidx_r == 2'd2) begin
          ex_r <= xh_r;
          ey_r <= rk4_pkg::sat_word(64'(y_r) + 64'(mul_res));
        end else begin
          ex_r <= xm_r;
          ey_r <= rk4_pkg::sat_word(64'(y_r) + 64'(k_half));
        end
      end
      S_SUM6: sum_r <= SUM_W'(k_r[0]) + (SUM_W'(k_r[1]) <<< 1)
                     + (SUM_W'(k_r[2]) <<< 1) + SUM_W'(k_r[3]);
      S_DIVI: begin
        neg_r <= sum_r[SUM_W-1];
        num_r <= mag + NUM_W'(3);
        rem_r <= '0;
      end
      S_DIV: begin
        rem_r <= drem[REM_W-1:0];
        num_r <= {num_r[NUM_W-DIGIT_W-1:0], qd};
      end
      S_FIN: inc_r <= rk4_pkg::sat_word(neg_r ? -$signed(64'(num_r)) : $signed(64'(num_r)));
      S_UPD: begin
        if (out_free) begin
          out_chan.slope_one   <= k_r[0];
          out_chan.slope_two   <= k_r[1];
          out_chan.slope_three <= k_r[2];
          out_chan.slope_four  <= k_r[3];
          out_chan.increment   <= inc_r;
          out_chan.x_after     <= xh_r;
          out_chan.y_after     <= rk4_pkg::sat_word(64'(y_r) + 64'(inc_r));
        end
      end
      default: ;
    endcase
  end

endmodule
